// File: src/r2h_pkg.sv
// Shared types and constants of the RGB to HSV converter.
`default_nettype none

package r2h_pkg;

  // Result field widths, fixed whatever the channel width.
  localparam int HUE_BITS = 15;
  localparam int SAT_BITS = 13;

  // Quotient bits produced by each divider, one per pipeline stage.
  localparam int QUOT_BITS = 13;

  // Saturation is scaled by 2**SAT_FRAC_BITS before the divide.
  localparam int SAT_FRAC_BITS = 12;

  // Hue in degrees times 64: one 60-degree sector and the full circle.
  localparam int HUE_SECTOR = 3840;
  localparam int HUE_FULL = 23040;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Which channel holds the maximum; red wins ties, then green.
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } r2h_sector_t;

  // Classification of one pixel, handed from front to back.
  typedef struct packed {
    r2h_sector_t sector;
    logic        neg;
    logic        grey;
  } r2h_class_t;

endpackage

`default_nettype wire

// File: src/r2h_front.sv
// Front end: finds max, min, delta and the hue sector of one pixel.
`default_nettype none

module r2h_front
  import r2h_pkg::*;
#(
  parameter int CHANNEL_BITS = 8
) (
  input  wire logic [CHANNEL_BITS-1:0] red,
  input  wire logic [CHANNEL_BITS-1:0] green,
  input  wire logic [CHANNEL_BITS-1:0] blue,
  output logic      [CHANNEL_BITS-1:0] max_val,
  output logic      [CHANNEL_BITS-1:0] delta,
  output logic      [CHANNEL_BITS-1:0] diff_mag,
  output r2h_class_t                   cls
);

  logic [CHANNEL_BITS-1:0] min_val;
  logic [CHANNEL_BITS-1:0] op_a;
  logic [CHANNEL_BITS-1:0] op_b;
  r2h_sector_t             sector;
  logic                    neg;

  // Pick the largest channel and the pair whose difference sets the hue.
  always_comb begin
    if (red >= green && red >= blue) begin
      max_val = red;
      sector  = SEC_RED;
      op_a    = green;
      op_b    = blue;
    end else if (green >= blue) begin
      max_val = green;
      sector  = SEC_GREEN;
      op_a    = blue;
      op_b    = red;
    end else begin
      max_val = blue;
      sector  = SEC_BLUE;
      op_a    = red;
      op_b    = green;
    end
  end

  // Smallest channel.
  always_comb begin
    min_val = (red < green) ? red : green;
    if (blue < min_val) begin
      min_val = blue;
    end
  end

  // Spread, sign and magnitude of the hue difference.
  assign delta    = max_val - min_val;
  assign neg      = (op_a < op_b);
  assign diff_mag = neg ? (op_b - op_a) : (op_a - op_b);
  assign cls      = '{sector: sector, neg: neg, grey: (delta == '0)};

endmodule

`default_nettype wire

// File: src/r2h_queue.sv
// Short first-in first-out queue between front and back.
`default_nettype none

module r2h_queue
  import r2h_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic      [WIDTH-1:0] rd_data
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;
  logic                push;
  logic                pop;

  assign wr_ready = (count_r != CNT_BITS'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr_r];

  // Pointer and fill count updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage; entries need no reset as the count guards every read.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // A word pushed into an empty queue is offered at the read side next cycle.
  a_push_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (push && count_r == '0) |=> (rd_valid && rd_data == $past(wr_data)))
    else $error("queue lost a word written while empty");
`endif

endmodule

`default_nettype wire

// File: src/r2h_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module r2h_div #(
  parameter int DW = 8,
  parameter int QW = 13
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DW+QW-2:0] num,
  input  wire logic [DW-1:0]    den,
  output logic      [QW-1:0]    quot
);

  // The numerator must stay below den * 2**QW, so its top part is
  // already a valid partial remainder.
  logic [DW-1:0] src_rem [QW];
  logic [QW-1:0] src_lo  [QW];
  logic [QW-1:0] src_quo [QW];
  logic [DW-1:0] src_den [QW];
  logic [DW-1:0] rem_r   [QW];
  logic [QW-1:0] lo_r    [QW];
  logic [QW-1:0] quo_r   [QW];
  logic [DW-1:0] den_r   [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] sub;
    logic        take;

    // Stage input: the operands for the first stage, the previous stage after.
    if (s == 0) begin : g_first
      assign src_rem[s] = {1'b0, num[DW+QW-2:QW]};
      assign src_lo[s]  = num[QW-1:0];
      assign src_quo[s] = '0;
      assign src_den[s] = den;
    end else begin : g_next
      assign src_rem[s] = rem_r[s-1];
      assign src_lo[s]  = lo_r[s-1];
      assign src_quo[s] = quo_r[s-1];
      assign src_den[s] = den_r[s-1];
    end

    // Shift in the next numerator bit and subtract where the divisor fits.
    assign trial = {src_rem[s], src_lo[s][QW-1]};
    assign sub   = trial - {1'b0, src_den[s]};
    assign take  = (trial >= {1'b0, src_den[s]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= take ? sub[DW-1:0] : trial[DW-1:0];
        lo_r[s]  <= {src_lo[s][QW-2:0], 1'b0};
        quo_r[s] <= {src_quo[s][QW-2:0], take};
        den_r[s] <= src_den[s];
      end
    end
  end

  assign quot = quo_r[QW-1];

endmodule

`default_nettype wire

// File: src/r2h_back.sv
// Back end: saturation and hue dividers, hue assembly and output register.
`default_nettype none

module r2h_back
  import r2h_pkg::*;
#(
  parameter int CHANNEL_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [CHANNEL_BITS-1:0] in_value,
  input  wire logic [CHANNEL_BITS-1:0] in_delta,
  input  wire logic [CHANNEL_BITS-1:0] in_diff,
  input  wire r2h_class_t              in_cls,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic      [HUE_BITS-1:0]     out_hue,
  output logic      [SAT_BITS-1:0]     out_saturation,
  output logic      [CHANNEL_BITS-1:0] out_value
);

  localparam int NUM_BITS = CHANNEL_BITS + QUOT_BITS - 1;
  localparam int LAST     = QUOT_BITS - 1;
  localparam int HW       = HUE_BITS + 1;

  logic                    advance;
  logic [NUM_BITS-1:0]     sat_num;
  logic [NUM_BITS-1:0]     hue_num;
  logic [NUM_BITS-1:0]     diff_ext;
  logic [QUOT_BITS-1:0]    sat_quot;
  logic [QUOT_BITS-1:0]    hue_quot;
  logic                    vld_r   [QUOT_BITS];
  logic [CHANNEL_BITS-1:0] value_r [QUOT_BITS];
  r2h_class_t              cls_r   [QUOT_BITS];
  logic [HW-1:0]           offset;
  logic [HW-1:0]           frac;
  logic [HW-1:0]           hue_w;
  logic [SAT_BITS-1:0]     sat_w;
  logic                    out_valid_r;
  logic [HUE_BITS-1:0]     out_hue_r;
  logic [SAT_BITS-1:0]     out_sat_r;
  logic [CHANNEL_BITS-1:0] out_value_r;

  // The whole pipeline moves whenever the output register can take a word.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  // Numerators: delta scaled to Q8.12 for 8-bit channels, and the difference times one sector.
  assign sat_num  = {in_delta, {SAT_FRAC_BITS{1'b0}}};
  assign diff_ext = NUM_BITS'(in_diff);
  assign hue_num  = (diff_ext << 12) - (diff_ext << 8);

  r2h_div #(
    .DW (CHANNEL_BITS),
    .QW (QUOT_BITS)
  ) u_sat_div (
    .clk  (clk),
    .en   (advance),
    .num  (sat_num),
    .den  (in_value),
    .quot (sat_quot)
  );

  r2h_div #(
    .DW (CHANNEL_BITS),
    .QW (QUOT_BITS)
  ) u_hue_div (
    .clk  (clk),
    .en   (advance),
    .num  (hue_num),
    .den  (in_delta),
    .quot (hue_quot)
  );

  // Valid bits and side information travel alongside the divider stages.
  for (genvar s = 0; s < QUOT_BITS; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (advance) begin
        vld_r[s] <= (s == 0) ? in_valid : vld_r[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        if (s == 0) begin
          value_r[s] <= in_value;
          cls_r[s]   <= in_cls;
        end else begin
          value_r[s] <= value_r[(s == 0) ? 0 : s-1];
          cls_r[s]   <= cls_r[(s == 0) ? 0 : s-1];
        end
      end
    end
  end

  // Sector offset in degrees times 64.
  always_comb begin
    unique case (cls_r[LAST].sector)
      SEC_RED:   offset = '0;
      SEC_GREEN: offset = HW'(2 * HUE_SECTOR);
      SEC_BLUE:  offset = HW'(4 * HUE_SECTOR);
      default:   offset = '0;
    endcase
  end

  // Hue: offset plus signed fraction, wrapped into one full circle.
  assign frac = HW'(hue_quot);

  always_comb begin
    if (cls_r[LAST].grey) begin
      hue_w = '0;
      sat_w = '0;
    end else begin
      sat_w = SAT_BITS'(sat_quot);
      if (!cls_r[LAST].neg) begin
        hue_w = offset + frac;
      end else if (offset >= frac) begin
        hue_w = offset - frac;
      end else begin
        hue_w = offset + HW'(HUE_FULL) - frac;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (advance && vld_r[LAST]) begin
      out_hue_r   <= hue_w[HUE_BITS-1:0];
      out_sat_r   <= sat_w;
      out_value_r <= value_r[LAST];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = out_hue_r;
  assign out_saturation = out_sat_r;
  assign out_value      = out_value_r;

`ifndef SYNTHESIS
  // A grey pixel leaves with zero hue and zero saturation.
  a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && vld_r[LAST] && cls_r[LAST].grey)
      |=> (out_hue == '0 && out_saturation == '0))
    else $error("grey pixel with non-zero hue or saturation");

  // Hue stays inside one full circle.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue < HUE_BITS'(HUE_FULL)))
    else $error("hue out of range");

  // Saturation never exceeds one.
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_saturation <= SAT_BITS'(1 << SAT_FRAC_BITS)))
    else $error("saturation above one");

  // A waiting result holds while the consumer stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hue)
      && $stable(out_saturation) && $stable(out_value)))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// File: src/rgb_to_hsv_top.sv
// Top level of the RGB to HSV converter: front end, queue and back end.
`default_nettype none

// Converts one RGB pixel per clock into hue (degrees times 64, 0 to 23039),
// saturation (unsigned Q1.12, 4096 is 1.0) and value (the largest channel).
// The sustained rate is one pixel per cycle while the consumer takes results.
// A pixel passes in order through the two-word queue behind the classifying
// front end, which is written at the accepting edge and feeds the back end
// directly, the thirteen stages of the restoring dividers, which produce one
// quotient bit per stage, and the output register. The queue lets the input
// side keep accepting for two words while the back end is stalled. No state
// needs clearing after reset beyond the control registers.
module rgb_to_hsv_top
  import r2h_pkg::*;
#(
  parameter int CHANNEL_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [CHANNEL_BITS-1:0] in_red,
  input  wire logic [CHANNEL_BITS-1:0] in_green,
  input  wire logic [CHANNEL_BITS-1:0] in_blue,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic      [HUE_BITS-1:0]     out_hue,
  output logic      [SAT_BITS-1:0]     out_saturation,
  output logic      [CHANNEL_BITS-1:0] out_value
);

  localparam int CLS_BITS = $bits(r2h_class_t);
  localparam int Q_WIDTH  = 3 * CHANNEL_BITS + CLS_BITS;

  logic [CHANNEL_BITS-1:0] f_max;
  logic [CHANNEL_BITS-1:0] f_delta;
  logic [CHANNEL_BITS-1:0] f_diff;
  r2h_class_t              f_cls;
  logic [Q_WIDTH-1:0]      q_wr_data;
  logic [Q_WIDTH-1:0]      q_rd_data;
  logic                    q_rd_valid;
  logic                    q_rd_ready;
  logic [CHANNEL_BITS-1:0] b_value;
  logic [CHANNEL_BITS-1:0] b_delta;
  logic [CHANNEL_BITS-1:0] b_diff;
  r2h_class_t              b_cls;

  r2h_front #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .max_val  (f_max),
    .delta    (f_delta),
    .diff_mag (f_diff),
    .cls      (f_cls)
  );

  // Pack the classified pixel into one queue word.
  assign q_wr_data = {f_max, f_delta, f_diff, f_cls};

  r2h_queue #(
    .WIDTH (Q_WIDTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  assign {b_value, b_delta, b_diff, b_cls} = q_rd_data;

  r2h_back #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (q_rd_valid),
    .in_ready       (q_rd_ready),
    .in_value       (b_value),
    .in_delta       (b_delta),
    .in_diff        (b_diff),
    .in_cls         (b_cls),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_value      (out_value)
  );

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the RGB to HSV converter, with its own pixel predictor.
`default_nettype none

module tb_top;
  import r2h_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH_BITS = 8;
  localparam int CH_MAX = (1 << CH_BITS) - 1;
  localparam int RANDOM_PER_PHASE = 490;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 100;

  // One converted pixel as the block presents it.
  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    logic [SAT_BITS-1:0] saturation;
    logic [CH_BITS-1:0]  value;
  } hsv_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CH_BITS-1:0]  in_red = '0;
  logic [CH_BITS-1:0]  in_green = '0;
  logic [CH_BITS-1:0]  in_blue = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [HUE_BITS-1:0] out_hue;
  logic [SAT_BITS-1:0] out_saturation;
  logic [CH_BITS-1:0]  out_value;

  hsv_word_t   hsv_expected_q[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          pixels_sent = 0;
  int          grey_sent = 0;
  int          results_checked = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  rgb_to_hsv_top #(
    .CHANNEL_BITS(CH_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_value     (out_value)
  );

  // Free-running clock, 10 ns period.
  always #5 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, hsv_expected_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Signed channel difference scaled to one hue sector, truncated toward zero.
  function automatic int sector_fraction(input int a, input int b, input int delta);
    int mag;
    if (a >= b) begin
      mag = ((a - b) * HUE_SECTOR) / delta;
      return mag;
    end
    mag = ((b - a) * HUE_SECTOR) / delta;
    return -mag;
  endfunction

  // Expected hue, saturation and value of one pixel.
  function automatic hsv_word_t predict_hsv(input logic [CH_BITS-1:0] r,
                                            input logic [CH_BITS-1:0] g,
                                            input logic [CH_BITS-1:0] b);
    int          rv, gv, bv, mx, mn, delta, h;
    r2h_sector_t sector;
    hsv_word_t   res;
    rv = int'(r);
    gv = int'(g);
    bv = int'(b);
    mx = (rv > gv) ? rv : gv;
    mx = (mx > bv) ? mx : bv;
    mn = (rv < gv) ? rv : gv;
    mn = (mn < bv) ? mn : bv;
    delta = mx - mn;
    res = '0;
    res.value = mx[CH_BITS-1:0];
    if (delta != 0) begin
      res.saturation = SAT_BITS'((delta << SAT_FRAC_BITS) / mx);
      // Red wins ties for the maximum, then green.
      if (rv == mx) sector = SEC_RED;
      else if (gv == mx) sector = SEC_GREEN;
      else sector = SEC_BLUE;
      case (sector)
        SEC_RED: begin
          h = sector_fraction(gv, bv, delta);
        end
        SEC_GREEN: begin
          h = 2 * HUE_SECTOR + sector_fraction(bv, rv, delta);
        end
        default: begin
          h = 4 * HUE_SECTOR + sector_fraction(rv, gv, delta);
        end
      endcase
      if (h < 0) h += HUE_FULL;
      res.hue = h[HUE_BITS-1:0];
    end
    return res;
  endfunction

  // Prints one line per discrepancy, up to a limit, and counts every one.
  task automatic report_error(input string what, input int got, input int want);
    if (error_count < PRINT_LIMIT)
      $display("error at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Drives one pixel word and waits until it is accepted.
  task automatic send_pixel(input logic [CH_BITS-1:0] r,
                            input logic [CH_BITS-1:0] g,
                            input logic [CH_BITS-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    hsv_expected_q.push_back(predict_hsv(r, g, b));
    pixels_sent++;
    if (r == g && g == b) grey_sent++;
  endtask

  // Sends one pixel given as integer channel levels.
  task automatic send_levels(input int r, input int g, input int b);
    send_pixel(CH_BITS'(r), CH_BITS'(g), CH_BITS'(b));
  endtask

  // Receiver back-pressure, redrawn each cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compares every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    hsv_word_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (hsv_expected_q.size() == 0) begin
        report_error("unexpected result word, hue", int'(out_hue), 0);
      end else begin
        want = hsv_expected_q.pop_front();
        results_checked++;
        if (out_hue !== want.hue) report_error("hue", int'(out_hue), int'(want.hue));
        if (out_saturation !== want.saturation)
          report_error("saturation", int'(out_saturation), int'(want.saturation));
        if (out_value !== want.value)
          report_error("value", int'(out_value), int'(want.value));
      end
    end
  end

  // Chooses a random pixel, biased towards grey, tied and nearly grey pixels.
  task automatic pick_pixel(output logic [CH_BITS-1:0] r,
                            output logic [CH_BITS-1:0] g,
                            output logic [CH_BITS-1:0] b);
    int                 kind;
    logic [CH_BITS-1:0] base;
    logic [CH_BITS-1:0] other;
    kind  = $urandom_range(0, 99);
    base  = CH_BITS'($urandom);
    r     = CH_BITS'($urandom);
    g     = CH_BITS'($urandom);
    b     = CH_BITS'($urandom);
    if (kind < 10) begin
      r = base;
      g = base;
      b = base;
    end else if (kind < 25) begin
      // Two channels share the maximum.
      other = CH_BITS'($urandom_range(0, base));
      case ($urandom_range(0, 2))
        0: begin
          r = base; g = base; b = other;
        end
        1: begin
          r = other; g = base; b = base;
        end
        default: begin
          r = base; g = other; b = base;
        end
      endcase
    end else if (kind < 40) begin
      // Small delta, where the divisions are coarsest.
      r = base;
      g = base ^ CH_BITS'($urandom_range(0, 3));
      b = base ^ CH_BITS'($urandom_range(0, 3));
    end
  endtask

  // Extremes, pure primaries, ties for the maximum and hue wrap-around.
  task automatic test_directed_pixels();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_levels(0, 0, 0);
    send_levels(CH_MAX, CH_MAX, CH_MAX);
    send_levels(128, 128, 128);
    send_levels(CH_MAX, 0, 0);
    send_levels(0, CH_MAX, 0);
    send_levels(0, 0, CH_MAX);
    send_levels(CH_MAX, CH_MAX, 0);
    send_levels(0, CH_MAX, CH_MAX);
    send_levels(CH_MAX, 0, CH_MAX);
    send_levels(CH_MAX, 0, 1);
    send_levels(CH_MAX, 1, 0);
    send_levels(1, 0, 0);
    send_levels(0, 1, 1);
    send_levels(1, 1, 0);
    send_levels(CH_MAX, CH_MAX - 1, CH_MAX - 1);
    send_levels(CH_MAX - 1, CH_MAX, CH_MAX);
    send_levels(CH_MAX, CH_MAX, CH_MAX - 1);
    send_levels(200, 100, 50);
    send_levels(50, 200, 100);
    send_levels(100, 50, 200);
    send_levels(10, 200, CH_MAX);
    send_levels(170, 85, 0);
  endtask

  // Random pixels under one pattern of sender gaps and receiver stalls.
  task automatic test_random_pixels(input int unsigned idle_pct, input int unsigned stall_pct);
    logic [CH_BITS-1:0] r, g, b;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      pick_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  // Reset, stimulus phases, drain and verdict.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_pixels();
    test_random_pixels(0, 0);
    test_random_pixels(81, 0);
    test_random_pixels(0, 81);
    test_random_pixels(18, 18);

    @(negedge clk);
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (hsv_expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d pixels (%0d grey) under four idle and stall patterns;",
             pixels_sent, grey_sent);
    $display("%0d result words compared, %0d discrepancies.", results_checked, error_count);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
src/r2h_pkg.sv
src/r2h_front.sv
src/r2h_queue.sv
src/r2h_div.sv
src/r2h_back.sv
src/rgb_to_hsv_top.sv
sim/tb_top.sv
